>>> rtl/tpps_pkg.sv
// Shared types, codes and constants for the timed pick-and-place sequencer.
package tpps_pkg;

    localparam int STAMP_WIDTH_DEF = 32;
    localparam int DWELL_WIDTH_DEF = 16;

    localparam int NUM_DWELL = 7;
    localparam int CFG_IDX_W = 3;

    // dwell register indexes
    localparam logic [CFG_IDX_W-1:0] DW_WORK     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] DW_EXTEND   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] DW_GRIP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] DW_RETRACT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] DW_TRANSFER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] DW_RELEASE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] DW_HOME     = 3'd6;

    // reset dwell values in ms, wide enough for the largest dwell width
    localparam logic [31:0] DWELL_RESET [NUM_DWELL] = '{
        32'd600, 32'd500, 32'd250, 32'd500, 32'd700, 32'd250, 32'd500
    };

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_WORK     = 4'd1,
        ST_EXTEND   = 4'd2,
        ST_GRIP     = 4'd3,
        ST_RETRACT  = 4'd4,
        ST_TRANSFER = 4'd5,
        ST_DROP     = 4'd6,
        ST_HOME     = 4'd7,
        ST_TRIP     = 4'd8
    } step_t;

    typedef enum logic [1:0] {
        SERVO_NONE = 2'd0,
        SERVO_WORK = 2'd1,
        SERVO_XFER = 2'd2
    } servo_t;

    typedef enum logic [1:0] {
        PUSH_NONE    = 2'd0,
        PUSH_EXTEND  = 2'd1,
        PUSH_RETRACT = 2'd2
    } pusher_t;

    typedef enum logic [1:0] {
        MAG_KEEP    = 2'd0,
        MAG_ON      = 2'd1,
        MAG_RELEASE = 2'd2
    } magnet_t;

    // operation codes of an input item
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // result item, step_code in the lowest bits
    typedef struct packed {
        logic       holding;
        logic       lift_halt;
        magnet_t    magnet_cmd;
        pusher_t    pusher_cmd;
        servo_t     servo_cmd;
        logic       step_entered;
        logic [3:0] step_code;
    } result_t;

    localparam int RES_W       = $bits(result_t);
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

>>> rtl/timed_pick_place_sequencer.sv
// Top level of the timed pick-and-place sequencer.
//
// Usage:
//   s_axis carries events. tuser = operation (0 start request, 1 tick).
//   tdata = {pad, stop_button, overcurrent, drive_alarm, now_stamp}, stamp in
//   the low bits. Every event yields exactly one result item on m_axis.
//   m_axis tdata = {pad, holding, lift_halt, magnet_cmd, pusher_cmd,
//   servo_cmd, step_entered, step_code}, step_code in the low bits.
//   cfg writes one of the seven dwell registers (index 0..6, ms); index 7
//   is ignored. cfg_ready is always high. Write only while idle.
// Timing:
//   Event is taken into an input register, evaluated by one level of
//   compare and state logic, and lands in the result register, which
//   drives m_axis_tvalid. One event per cycle sustained while m_axis_tready
//   stays high; the state update of one event is ready for the next in
//   the following cycle.
// Reset:
//   Step idle, entry stamp 0, holding clear, dwells at defaults, both
//   pipeline registers empty.
// Stall:
//   A held result stays in the output register; the input register keeps
//   accepting until it holds an event too, then s_axis_tready drops.
module timed_pick_place_sequencer
    import tpps_pkg::*;
#(
    parameter int STAMP_WIDTH = STAMP_WIDTH_DEF,
    parameter int DWELL_WIDTH = DWELL_WIDTH_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // now_stamp, drive_alarm, overcurrent, stop_button, zero pad
    input  logic [((STAMP_WIDTH + 3 + 7) / 8) * 8-1:0] s_axis_tdata,
    // operation
    input  logic                                   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // step_code, step_entered, servo_cmd, pusher_cmd, magnet_cmd,
    // lift_halt, holding, zero pad
    output logic [OUT_TDATA_W-1:0]                 m_axis_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]                   cfg_index,
    input  logic [DWELL_WIDTH-1:0]                 cfg_data
);

    logic                                  in_valid_reg;
    logic                                  in_op_reg;
    logic [STAMP_WIDTH-1:0]                in_stamp_reg;
    logic [2:0]                            in_flags_reg;
    logic                                  out_valid_reg;
    result_t                               out_res_reg;
    logic                                  s_fire;
    logic                                  advance;
    logic [NUM_DWELL-1:0][DWELL_WIDTH-1:0] dwell;
    result_t                               res;

    // evaluate the held event when the result register is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_op_reg    <= s_axis_tuser;
            in_stamp_reg <= s_axis_tdata[STAMP_WIDTH-1:0];
            in_flags_reg <= s_axis_tdata[STAMP_WIDTH+2:STAMP_WIDTH];
        end
    end

    tpps_dwell_regs #(
        .DWELL_WIDTH (DWELL_WIDTH)
    ) u_dwell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dwell     (dwell)
    );

    tpps_step_logic #(
        .STAMP_WIDTH (STAMP_WIDTH),
        .DWELL_WIDTH (DWELL_WIDTH)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .item_op    (in_op_reg),
        .item_stamp (in_stamp_reg),
        .item_flags (in_flags_reg),
        .dwell      (dwell),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - RES_W)'(0), out_res_reg};

endmodule

>>> rtl/tpps_dwell_regs.sv
// Dwell configuration registers with their write port.
module tpps_dwell_regs
    import tpps_pkg::*;
#(
    parameter int DWELL_WIDTH = DWELL_WIDTH_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]                  cfg_index,
    input  logic [DWELL_WIDTH-1:0]                cfg_data,
    output logic [NUM_DWELL-1:0][DWELL_WIDTH-1:0] dwell
);

    logic [NUM_DWELL-1:0][DWELL_WIDTH-1:0] dwell_reg;

    // index seven has no register; such writes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DWELL; i++)
            begin
                dwell_reg[i] <= DWELL_RESET[i][DWELL_WIDTH-1:0];
            end
        end
        else
        begin
            for (int i = 0; i < NUM_DWELL; i++)
            begin
                if (cfg_valid && (cfg_index == CFG_IDX_W'(i)))
                begin
                    dwell_reg[i] <= cfg_data;
                end
            end
        end
    end

    assign dwell = dwell_reg;

endmodule

>>> rtl/tpps_step_logic.sv
// Sequencer state registers, dwell compare and per-item result logic.
module tpps_step_logic
    import tpps_pkg::*;
#(
    parameter int STAMP_WIDTH = STAMP_WIDTH_DEF,
    parameter int DWELL_WIDTH = DWELL_WIDTH_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  fire,
    input  logic                                  item_op,
    input  logic [STAMP_WIDTH-1:0]                item_stamp,
    input  logic [2:0]                            item_flags,
    input  logic [NUM_DWELL-1:0][DWELL_WIDTH-1:0] dwell,
    output result_t                               res
);

    localparam int CMP_W = (STAMP_WIDTH > DWELL_WIDTH) ? STAMP_WIDTH : DWELL_WIDTH;

    step_t                  step_reg;
    step_t                  step_next;
    logic [STAMP_WIDTH-1:0] entry_reg;
    logic [STAMP_WIDTH-1:0] entry_next;
    logic                   holding_reg;
    logic                   holding_next;
    logic                   entered;
    logic                   tick;
    logic                   trip;
    logic [STAMP_WIDTH-1:0] elapsed;
    logic [DWELL_WIDTH-1:0] dwell_sel;
    logic                   done;
    servo_t                 servo;
    pusher_t                pusher;
    magnet_t                magnet;
    logic                   halt;

    assign tick    = (item_op == OP_TICK);
    assign trip    = |item_flags;
    assign elapsed = item_stamp - entry_reg;   // wraps modulo 2^STAMP_WIDTH

    always_comb
    begin
        case (step_reg)
            ST_WORK:     dwell_sel = dwell[DW_WORK];
            ST_EXTEND:   dwell_sel = dwell[DW_EXTEND];
            ST_GRIP:     dwell_sel = dwell[DW_GRIP];
            ST_RETRACT:  dwell_sel = dwell[DW_RETRACT];
            ST_TRANSFER: dwell_sel = dwell[DW_TRANSFER];
            ST_DROP:     dwell_sel = dwell[DW_RELEASE];
            ST_HOME:     dwell_sel = dwell[DW_HOME];
            default:     dwell_sel = '0;
        endcase
    end

    assign done = (CMP_W'(elapsed) >= CMP_W'(dwell_sel));

    // next state
    always_comb
    begin
        step_next    = step_reg;
        entry_next   = entry_reg;
        holding_next = holding_reg;
        entered      = 1'b0;
        if (!tick)
        begin
            if (step_reg == ST_IDLE)
            begin
                step_next  = trip ? ST_TRIP : ST_WORK;
                entry_next = item_stamp;
                entered    = 1'b1;
            end
        end
        else if (trip)
        begin
            step_next  = ST_TRIP;
            entry_next = item_stamp;
            entered    = 1'b1;
        end
        else
        begin
            case (step_reg)
                ST_IDLE:     step_next = ST_IDLE;
                ST_WORK:     if (done) step_next = ST_EXTEND;
                ST_EXTEND:   if (done) step_next = ST_GRIP;
                ST_GRIP:
                begin
                    holding_next = 1'b1;
                    if (done) step_next = ST_RETRACT;
                end
                ST_RETRACT:  if (done) step_next = ST_TRANSFER;
                ST_TRANSFER: if (done) step_next = ST_DROP;
                ST_DROP:
                begin
                    holding_next = 1'b0;
                    if (done) step_next = ST_HOME;
                end
                ST_HOME:     if (done) step_next = ST_IDLE;
                default:     step_next = step_reg;
            endcase
            if (done && (step_reg != ST_IDLE) && (step_reg != ST_TRIP))
            begin
                entry_next = item_stamp;
                entered    = 1'b1;
            end
        end
    end

    // actuator commands; start items never drive actuators
    always_comb
    begin
        servo  = SERVO_NONE;
        pusher = PUSH_NONE;
        magnet = MAG_KEEP;
        halt   = 1'b0;
        if (tick && trip)
        begin
            magnet = MAG_RELEASE;
            halt   = 1'b1;
        end
        else if (tick)
        begin
            case (step_reg)
                ST_IDLE:     halt   = 1'b1;
                ST_WORK:     servo  = SERVO_WORK;
                ST_EXTEND:   pusher = PUSH_EXTEND;
                ST_GRIP:     magnet = MAG_ON;
                ST_RETRACT:  pusher = PUSH_RETRACT;
                ST_TRANSFER: servo  = SERVO_XFER;
                ST_DROP:     magnet = MAG_RELEASE;
                ST_HOME:     pusher = PUSH_RETRACT;
                default:
                begin
                    magnet = MAG_RELEASE;
                    halt   = 1'b1;
                    pusher = PUSH_RETRACT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= ST_IDLE;
            entry_reg   <= '0;
            holding_reg <= 1'b0;
        end
        else if (fire)
        begin
            step_reg    <= step_next;
            entry_reg   <= entry_next;
            holding_reg <= holding_next;
        end
    end

    always_comb
    begin
        res.step_code    = step_next;
        res.step_entered = entered;
        res.servo_cmd    = servo;
        res.pusher_cmd   = pusher;
        res.magnet_cmd   = magnet;
        res.lift_halt    = halt;
        res.holding      = holding_next;
    end

endmodule

>>> rtl/tpps_checker.sv
// Port-level checks for the sequencer, bound to the top level.
module tpps_checker
    import tpps_pkg::*;
#(
    parameter int STAMP_WIDTH = STAMP_WIDTH_DEF,
    parameter int DWELL_WIDTH = DWELL_WIDTH_DEF
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    result_t r;
    logic    fault_seen_reg;

    assign r = result_t'(m_axis_tdata[RES_W-1:0]);

    // once a result reports fault, every later result must too
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_seen_reg <= 1'b0;
        end
        else if (m_axis_tvalid && m_axis_tready && (r.step_code == ST_TRIP))
        begin
            fault_seen_reg <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && fault_seen_reg |-> r.step_code == ST_TRIP)
        else $error("left fault without reset");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> r.step_code <= ST_TRIP)
        else $error("step code out of range");

    a_magnet_on: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (r.magnet_cmd == MAG_ON) |->
            (r.step_code == ST_GRIP || r.step_code == ST_RETRACT) && r.holding)
        else $error("magnet energized outside grip");

endmodule

bind timed_pick_place_sequencer tpps_checker #(
    .STAMP_WIDTH (STAMP_WIDTH),
    .DWELL_WIDTH (DWELL_WIDTH)
) u_tpps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/sv/pick_place_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard package: predictor and result checker for the pick-and-place sequencer.
package tpps_tb_pkg;
    import tpps_pkg::*;

    class pick_place_scoreboard;
        logic [DWELL_WIDTH_DEF-1:0] dwell [NUM_DWELL];
        step_t                      step;
        logic [31:0]                entry_stamp;
        logic                       holding;
        result_t                    pending_results [$];
        int                         mismatches;

        function new();
            for (int i = 0; i < NUM_DWELL; i++)
                dwell[i] = DWELL_RESET[i][DWELL_WIDTH_DEF-1:0];
            step        = ST_IDLE;
            entry_stamp = '0;
            holding     = 1'b0;
            mismatches  = 0;
        endfunction

        function void write_dwell(logic [CFG_IDX_W-1:0] idx,
                                  logic [DWELL_WIDTH_DEF-1:0] value);
            if (idx < NUM_DWELL)
                dwell[idx] = value;
        endfunction

        // dwell of the working step we are in, 0 outside the working steps
        function logic [31:0] cur_dwell();
            if (step >= ST_WORK && step <= ST_HOME)
                return 32'(dwell[int'(step) - 1]);
            return '0;
        endfunction

        function bit dwell_elapsed(logic [31:0] now, int idx);
            logic [31:0] gone;
            gone = now - entry_stamp;
            return gone >= 32'(dwell[idx]);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // one accepted event -> one expected result
        function void take_event(logic op, logic [31:0] now, logic [2:0] flags);
            result_t r;
            bit      trip;
            bit      adv;
            step_t   nxt;
            r    = '0;
            trip = |flags;
            adv  = 1'b0;
            nxt  = step;
            if (op == OP_START)
            begin
                if (step == ST_IDLE)
                begin
                    adv = 1'b1;
                    if (trip)
                        nxt = ST_TRIP;
                    else
                        nxt = ST_WORK;
                end
            end
            else if (trip)
            begin
                r.magnet_cmd = MAG_RELEASE;
                r.lift_halt  = 1'b1;
                adv          = 1'b1;
                nxt          = ST_TRIP;
            end
            else
            begin
                case (step)
                    ST_IDLE: r.lift_halt = 1'b1;
                    ST_WORK:
                    begin
                        r.servo_cmd = SERVO_WORK;
                        adv = dwell_elapsed(now, DW_WORK);
                        nxt = ST_EXTEND;
                    end
                    ST_EXTEND:
                    begin
                        r.pusher_cmd = PUSH_EXTEND;
                        adv = dwell_elapsed(now, DW_EXTEND);
                        nxt = ST_GRIP;
                    end
                    ST_GRIP:
                    begin
                        r.magnet_cmd = MAG_ON;
                        holding = 1'b1;
                        adv = dwell_elapsed(now, DW_GRIP);
                        nxt = ST_RETRACT;
                    end
                    ST_RETRACT:
                    begin
                        r.pusher_cmd = PUSH_RETRACT;
                        adv = dwell_elapsed(now, DW_RETRACT);
                        nxt = ST_TRANSFER;
                    end
                    ST_TRANSFER:
                    begin
                        r.servo_cmd = SERVO_XFER;
                        adv = dwell_elapsed(now, DW_TRANSFER);
                        nxt = ST_DROP;
                    end
                    ST_DROP:
                    begin
                        r.magnet_cmd = MAG_RELEASE;
                        holding = 1'b0;
                        adv = dwell_elapsed(now, DW_RELEASE);
                        nxt = ST_HOME;
                    end
                    ST_HOME:
                    begin
                        r.pusher_cmd = PUSH_RETRACT;
                        adv = dwell_elapsed(now, DW_HOME);
                        nxt = ST_IDLE;
                    end
                    default:
                    begin
                        r.magnet_cmd = MAG_RELEASE;
                        r.lift_halt  = 1'b1;
                        r.pusher_cmd = PUSH_RETRACT;
                    end
                endcase
            end
            if (adv)
            begin
                step           = nxt;
                entry_stamp    = now;
                r.step_entered = 1'b1;
            end
            r.step_code = step;
            r.holding   = holding;
            pending_results.push_back(r);
        endfunction

        task report(string msg);
            if (mismatches < 40)
                $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task cmp_field(string name, int got, int want);
            if (got != want)
                report($sformatf("%s got %0d want %0d", name, got, want));
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] data);
            result_t got;
            result_t want;
            got = result_t'(data[RES_W-1:0]);
            if (pending_results.size() == 0)
            begin
                report($sformatf("result %h with no event outstanding", data));
                return;
            end
            want = pending_results.pop_front();
            if ($isunknown(data))
                report($sformatf("result %h has unknown bits", data));
            cmp_field("step_code", int'(got.step_code), int'(want.step_code));
            cmp_field("step_entered", int'(got.step_entered), int'(want.step_entered));
            cmp_field("servo_cmd", int'(got.servo_cmd), int'(want.servo_cmd));
            cmp_field("pusher_cmd", int'(got.pusher_cmd), int'(want.pusher_cmd));
            cmp_field("magnet_cmd", int'(got.magnet_cmd), int'(want.magnet_cmd));
            cmp_field("lift_halt", int'(got.lift_halt), int'(want.lift_halt));
            cmp_field("holding", int'(got.holding), int'(want.holding));
            cmp_field("pad", int'(data[OUT_TDATA_W-1:RES_W]), 0);
        endtask
    endclass

endpackage

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top-level testbench for the timed pick-and-place sequencer.
module testbench;
    import tpps_pkg::*;
    import tpps_tb_pkg::*;

    localparam int IN_TDATA_W  = ((STAMP_WIDTH_DEF + 3 + 7) / 8) * 8;
    localparam int PHASE_ITEMS = 270;

    // index past the dwell bank: the block must drop writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    // flag vectors are {stop_button, overcurrent, drive_alarm}
    localparam logic [2:0] FLAGS_CLEAR = 3'b000;
    localparam logic [2:0] FLAG_ALARM  = 3'b001;
    localparam logic [2:0] FLAG_OVERI  = 3'b010;
    localparam logic [2:0] FLAG_STOP   = 3'b100;
    localparam logic [2:0] FLAGS_ALL   = 3'b111;

    // dwell settings the random phases run under
    typedef enum int {
        PLAN_KEEP,      // reset defaults, untouched
        PLAN_ZERO,      // every dwell 0: each tick advances
        PLAN_MAX,       // every dwell at full scale
        PLAN_WIDE,      // uniform over the full range
        PLAN_SHORT,     // a few ms: many full cycles
        PLAN_MIXED,     // per register pick of extremes and mid values
        PLAN_COUNT
    } dwell_plan_t;

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [IN_TDATA_W-1:0]      s_axis_tdata;
    logic                       s_axis_tuser;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [DWELL_WIDTH_DEF-1:0] cfg_data;

    pick_place_scoreboard sb;

    // last stamp sent; each random phase restarts it near the wrap or at random
    logic [31:0] wall_ms;
    // calm stretches: no idling on that side until toggled off again
    bit          src_calm;
    bit          sink_calm;
    int          sink_wait;

    timed_pick_place_sequencer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Send one event. Valid drops only for a drawn gap; back-to-back items
    // keep it high. The predictor is updated at the accepting edge so that
    // the next item can be aimed at the current step's dwell boundary.
    task put_event(input logic op, input logic [31:0] now, input logic [2:0] flags);
        int gap;
        if ($urandom_range(0, 39) == 0)
            src_calm = !src_calm;
        gap = src_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_TDATA_W'({flags, now});
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        sb.take_event(op, now, flags);
        wall_ms = now;
    endtask

    // One register write; caller lowers cfg_valid after the last one.
    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DWELL_WIDTH_DEF-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.write_dwell(idx, value);
    endtask

    // Let the pipeline empty: lower valid and wait for every expected result back.
    task settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Walk the sequence home with ticks right on each dwell boundary.
    task drain_to_idle();
        while (sb.step != ST_IDLE)
            put_event(OP_TICK, sb.entry_stamp + sb.cur_dwell(), FLAGS_CLEAR);
    endtask

    task configure(input dwell_plan_t plan);
        logic [DWELL_WIDTH_DEF-1:0] v;
        int                         i;
        if (plan == PLAN_KEEP)
            return;
        // a write past the bank must leave every dwell as it was
        write_reg(CFG_IDX_UNUSED, DWELL_WIDTH_DEF'($urandom));
        for (i = 0; i < NUM_DWELL; i++)
        begin
            case (plan)
                PLAN_ZERO:  v = '0;
                PLAN_MAX:   v = '1;
                PLAN_WIDE:  v = DWELL_WIDTH_DEF'($urandom_range(0, 65535));
                PLAN_SHORT: v = DWELL_WIDTH_DEF'($urandom_range(0, 40));
                default:
                    case ($urandom_range(0, 3))
                        0:       v = '0;
                        1:       v = '1;
                        2:       v = DWELL_WIDTH_DEF'($urandom_range(1, 3));
                        default: v = DWELL_WIDTH_DEF'($urandom_range(0, 900));
                    endcase
            endcase
            write_reg(CFG_IDX_W'(i), v);
        end
        cfg_valid <= 1'b0;
    endtask

    // Directed pass under reset dwells: every step entered, each dwell hit
    // one ms short and then exactly, starts outside idle, the stamp wrap
    // and a stamp that runs backward.
    task directed_sweep();
        logic [31:0] base;
        put_event(OP_TICK, 32'd0, FLAGS_CLEAR);          // tick in idle holds the lift
        put_event(OP_START, 32'd100, FLAGS_CLEAR);
        put_event(OP_START, 32'd101, FLAGS_CLEAR);       // start while busy is dropped
        do
        begin
            base = sb.entry_stamp + sb.cur_dwell();
            put_event(OP_TICK, base - 32'd1, FLAGS_CLEAR);
            put_event(OP_TICK, base, FLAGS_CLEAR);
        end
        while (sb.step != ST_IDLE);
        // move-to-work entered just below the wrap point
        put_event(OP_START, 32'hFFFF_FF00, FLAGS_CLEAR);
        put_event(OP_TICK, 32'hFFFF_FFFF, FLAGS_CLEAR);
        put_event(OP_TICK, 32'h0000_0157, FLAGS_CLEAR);  // 599 ms after wrap
        put_event(OP_TICK, 32'h0000_0158, FLAGS_CLEAR);  // 600 ms: advance
        put_event(OP_TICK, 32'h0000_0000, FLAGS_CLEAR);  // backward: huge elapsed
    endtask

    // Random run of well-formed sequences. Most ticks land near the dwell
    // boundary or a little past the last stamp; some jump anywhere, some
    // repeat the stamp. A few starts arrive mid-sequence as noise and are
    // not counted.
    task random_cycles(input int count);
        int          counted;
        int          pick;
        logic [31:0] stamp;
        logic [31:0] d;
        counted = 0;
        if ($urandom_range(0, 3) == 0)
            wall_ms = 32'hFFFF_F000 + $urandom_range(0, 4095);
        else
            wall_ms = $urandom;
        while (counted < count)
        begin
            pick = $urandom_range(0, 99);
            if (sb.step == ST_IDLE)
            begin
                stamp = wall_ms + $urandom_range(0, 50);
                if (pick < 80)
                    put_event(OP_START, stamp, FLAGS_CLEAR);
                else
                    put_event(OP_TICK, stamp, FLAGS_CLEAR);
                counted++;
            end
            else if (pick < 8)
                put_event(OP_START, wall_ms + $urandom_range(0, 50), FLAGS_CLEAR);
            else
            begin
                d = sb.cur_dwell();
                if (pick < 22)
                    stamp = sb.entry_stamp + d - 32'd1;
                else if (pick < 36)
                    stamp = sb.entry_stamp + d;
                else if (pick < 40)
                    stamp = $urandom;
                else if (pick < 45)
                    stamp = wall_ms;
                else
                    stamp = wall_ms + $urandom_range(0, d / 2 + 3);
                put_event(OP_TICK, stamp, FLAGS_CLEAR);
                counted++;
            end
        end
    endtask

    // Fault is sticky until reset, so it comes last. Entry is either a start
    // with a flag raised in idle or a safety trip on a tick after a start;
    // afterwards every flag alone and together, ticks in fault, and starts
    // that must be dropped.
    task fault_phase();
        int          i;
        logic [2:0]  f;
        if ($urandom_range(0, 1) == 0)
            put_event(OP_START, $urandom, 3'($urandom_range(1, 7)));
        else
        begin
            put_event(OP_START, wall_ms, FLAGS_CLEAR);
            repeat ($urandom_range(0, 12))
                put_event(OP_TICK, sb.entry_stamp + sb.cur_dwell(), FLAGS_CLEAR);
            put_event(OP_TICK, $urandom, 3'($urandom_range(1, 7)));
        end
        put_event(OP_TICK, 32'h0000_0000, FLAG_ALARM);
        put_event(OP_TICK, 32'hFFFF_FFFF, FLAG_OVERI);
        put_event(OP_TICK, $urandom, FLAG_STOP);
        put_event(OP_TICK, $urandom, FLAGS_ALL);
        put_event(OP_TICK, $urandom, FLAGS_CLEAR);       // tick in fault, no trip
        put_event(OP_START, $urandom, FLAGS_ALL);
        for (i = 0; i < 120; i++)
        begin
            f = ($urandom_range(0, 1) == 1) ? 3'($urandom_range(0, 7)) : FLAGS_CLEAR;
            put_event(($urandom_range(0, 1) == 1) ? OP_TICK : OP_START, $urandom, f);
        end
    endtask

    // Result side: check every accepted result, then draw the stall
    // before the next one.
    initial
    begin
        m_axis_tready <= 1'b0;
        sink_wait = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            begin
                sb.check_result(m_axis_tdata);
                if ($urandom_range(0, 39) == 0)
                    sink_calm = !sink_calm;
                sink_wait = sink_calm ? 0 : $urandom_range(0, 14);
            end
            else if (sink_wait > 0)
                sink_wait--;
            m_axis_tready <= (sink_wait == 0);
        end
    end

    // Main sequence: reset, directed sweep, one random phase per dwell
    // plan with writes only while the block sits empty in idle, then the
    // fault phase and the verdict.
    initial
    begin
        int plan_idx;
        sb = new();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_START;
        cfg_valid     <= 1'b0;
        cfg_index     <= DW_WORK;
        cfg_data      <= '0;
        wall_ms       = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_sweep();
        drain_to_idle();
        settle();

        for (plan_idx = 0; plan_idx < int'(PLAN_COUNT); plan_idx++)
        begin
            configure(dwell_plan_t'(plan_idx));
            random_cycles(PHASE_ITEMS);
            drain_to_idle();
            settle();
        end

        fault_phase();
        settle();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
